// File: hdl/ascii_integer_line_parser_unit_assert.svh
// Assertion macros for the integer line parser.
`ifndef ASCII_INTEGER_LINE_PARSER_UNIT_ASSERT_SVH
`define ASCII_INTEGER_LINE_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ALIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define ALIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/alip_pkg.sv
// Types, constants and helpers shared by the integer line parser.
package alip_pkg;

  localparam int unsigned ACC_W  = 64;
  localparam int unsigned PROD_W = ACC_W + 4;

  localparam logic [ACC_W-1:0] MAG_CAP = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [4:0] HEX_BAD = 5'd16;

  localparam logic [ACC_W-1:0] LIM8_POS  = 64'd127;
  localparam logic [ACC_W-1:0] LIM8_NEG  = 64'd128;
  localparam logic [ACC_W-1:0] LIM16_POS = 64'd32767;
  localparam logic [ACC_W-1:0] LIM16_NEG = 64'd32768;

  typedef enum logic [1:0] {
    WM_8BIT  = 2'd0,
    WM_16BIT = 2'd1,
    WM_32BIT = 2'd2,
    WM_ALT32 = 2'd3
  } width_mode_e;

  localparam logic [1:0] WIDTH_MODE_RST = WM_32BIT;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_NODIG   = 2'd1,
    ERR_RANGE   = 2'd2,
    ERR_STREAM  = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    RX_DEC  = 2'd0,
    RX_OCT  = 2'd1,
    RX_HEX  = 2'd2,
    RX_NONE = 2'd3
  } radix_e;

  typedef enum logic [7:0] {
    PH_START    = 8'b0000_0001,
    PH_BLANKS   = 8'b0000_0010,
    PH_SIGNED   = 8'b0000_0100,
    PH_ZERO     = 8'b0000_1000,
    PH_HEXPFX   = 8'b0001_0000,
    PH_DIGITS   = 8'b0010_0000,
    PH_TAIL     = 8'b0100_0000,
    PH_AFTER_CR = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic              emit;
    logic signed [31:0] value;
    err_e              error_code;
    logic [31:0]       line_number;
  } step_res_t;

  // Digit value of a hex character, HEX_BAD when it is none.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = HEX_BAD;
    if (c inside {[8'h30:8'h39]}) r = 5'(c - 8'h30);
    else if (c inside {[8'h61:8'h66]}) r = 5'(c - 8'h57);
    else if (c inside {[8'h41:8'h46]}) r = 5'(c - 8'h37);
    return r;
  endfunction

endpackage

// File: hdl/alip_if.sv
// Request channel interfaces: characters in, parsed line results out.
interface alip_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       stream_end;

  modport source (output valid, output char_byte, output stream_end, input ready);
  modport sink   (input valid, input char_byte, input stream_end, output ready);
endinterface

interface alip_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         error_code;
  logic [31:0]        line_number;

  modport source (output valid, output value, output error_code, output line_number,
                  input ready);
  modport sink   (input valid, input value, input error_code, input line_number,
                  output ready);
endinterface

// File: hdl/alip_core.sv
// Parser state and the single-step next-state and result logic.
module alip_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          char_byte_i,
  input  logic                stream_end_i,
  input  logic [1:0]          width_mode_i,
  output alip_pkg::step_res_t res_o
);

  alip_pkg::phase_e               ph_q, ph_d;
  logic                           neg_q, neg_d;
  alip_pkg::radix_e               rx_q, rx_d;
  logic [alip_pkg::ACC_W-1:0]     acc_q, acc_d;
  logic                           stop_q, stop_d;
  logic [31:0]                    lines_q, lines_d;

  // base state for the character step (fresh line after a CR run)
  alip_pkg::phase_e               b_ph;
  logic                           b_neg;
  alip_pkg::radix_e               b_rx;
  logic [alip_pkg::ACC_W-1:0]     b_acc;
  logic                           b_stop;

  alip_pkg::phase_e               lc_ph;
  logic                           lc_neg;
  alip_pkg::radix_e               lc_rx;
  logic [alip_pkg::ACC_W-1:0]     lc_acc;
  logic                           lc_stop;

  logic [4:0]                     hv;
  logic                           is_dec;
  alip_pkg::radix_e               mac_rx;
  logic [alip_pkg::PROD_W-1:0]    prod;
  logic [alip_pkg::ACC_W-1:0]     mac_acc;

  logic                           emit;
  alip_pkg::err_e                 err_in;
  alip_pkg::radix_e               emit_rx;
  alip_pkg::err_e                 err_out;
  logic [alip_pkg::ACC_W-1:0]     mag;
  logic [31:0]                    val;

  assign hv     = alip_pkg::hex_val(char_byte_i);
  assign is_dec = (char_byte_i inside {[8'h30:8'h39]});

  always_comb begin
    if (ph_q == alip_pkg::PH_AFTER_CR) begin
      b_ph   = alip_pkg::PH_START;
      b_neg  = 1'b0;
      b_rx   = alip_pkg::RX_DEC;
      b_acc  = '0;
      b_stop = 1'b0;
    end else begin
      b_ph   = ph_q;
      b_neg  = neg_q;
      b_rx   = rx_q;
      b_acc  = acc_q;
      b_stop = stop_q;
    end
  end

  // shift-add by the radix, saturating at the magnitude cap
  always_comb begin
    if (b_ph == alip_pkg::PH_ZERO) mac_rx = alip_pkg::RX_OCT;
    else if (b_ph == alip_pkg::PH_HEXPFX) mac_rx = alip_pkg::RX_HEX;
    else mac_rx = b_rx;
    case (mac_rx)
      alip_pkg::RX_HEX: prod = {b_acc, 4'b0} + alip_pkg::PROD_W'(hv);
      alip_pkg::RX_OCT: prod = {1'b0, b_acc, 3'b0} + alip_pkg::PROD_W'(hv);
      default: prod = {1'b0, b_acc, 3'b0} + {3'b0, b_acc, 1'b0} + alip_pkg::PROD_W'(hv);
    endcase
    if (prod > alip_pkg::PROD_W'(alip_pkg::MAG_CAP)) mac_acc = alip_pkg::MAG_CAP;
    else mac_acc = prod[alip_pkg::ACC_W-1:0];
  end

  // one ordinary character on the line
  always_comb begin
    lc_ph   = b_ph;
    lc_neg  = b_neg;
    lc_rx   = b_rx;
    lc_acc  = b_acc;
    lc_stop = b_stop;
    case (b_ph)
      alip_pkg::PH_START, alip_pkg::PH_BLANKS, alip_pkg::PH_SIGNED: begin
        if (b_ph != alip_pkg::PH_SIGNED && (char_byte_i == alip_pkg::CH_SPACE ||
            char_byte_i == alip_pkg::CH_TAB || char_byte_i == alip_pkg::CH_VT ||
            char_byte_i == alip_pkg::CH_FF)) begin
          lc_ph = alip_pkg::PH_BLANKS;
        end else if (b_ph != alip_pkg::PH_SIGNED && char_byte_i == alip_pkg::CH_MINUS) begin
          lc_neg = 1'b1;
          lc_ph  = alip_pkg::PH_SIGNED;
        end else if (b_ph != alip_pkg::PH_SIGNED && char_byte_i == alip_pkg::CH_PLUS) begin
          lc_ph = alip_pkg::PH_SIGNED;
        end else if (char_byte_i == alip_pkg::CH_ZERO) begin
          lc_ph = alip_pkg::PH_ZERO;
        end else if (is_dec) begin
          lc_rx  = alip_pkg::RX_DEC;
          lc_acc = alip_pkg::ACC_W'(hv);
          lc_ph  = alip_pkg::PH_DIGITS;
        end else begin
          lc_rx = alip_pkg::RX_NONE;
          lc_ph = alip_pkg::PH_TAIL;
        end
      end
      alip_pkg::PH_ZERO: begin
        if (char_byte_i == alip_pkg::CH_X) begin
          lc_ph = alip_pkg::PH_HEXPFX;
        end else if (is_dec) begin
          lc_rx = alip_pkg::RX_OCT;
          lc_ph = alip_pkg::PH_DIGITS;
          if (hv >= 5'd8) lc_stop = 1'b1;
          else lc_acc = mac_acc;
        end else begin
          lc_ph = alip_pkg::PH_TAIL;
        end
      end
      alip_pkg::PH_HEXPFX: begin
        if (hv != alip_pkg::HEX_BAD) begin
          lc_rx  = alip_pkg::RX_HEX;
          lc_ph  = alip_pkg::PH_DIGITS;
          lc_acc = mac_acc;
        end else begin
          lc_rx = alip_pkg::RX_NONE;
          lc_ph = alip_pkg::PH_TAIL;
        end
      end
      alip_pkg::PH_DIGITS: begin
        if (hv == alip_pkg::HEX_BAD || (b_rx != alip_pkg::RX_HEX && hv > 5'd9)) begin
          lc_ph = alip_pkg::PH_TAIL;
        end else if (b_rx == alip_pkg::RX_OCT) begin
          if (b_stop || hv >= 5'd8) lc_stop = 1'b1;
          else lc_acc = mac_acc;
        end else begin
          lc_acc = mac_acc;
        end
      end
      default: ;
    endcase
  end

  // line ends, stream end and state update
  always_comb begin
    ph_d    = ph_q;
    neg_d   = neg_q;
    rx_d    = rx_q;
    acc_d   = acc_q;
    stop_d  = stop_q;
    emit    = 1'b0;
    err_in  = alip_pkg::ERR_OK;
    emit_rx = rx_q;
    if (stream_end_i) begin
      if (ph_q != alip_pkg::PH_START) begin
        emit   = 1'b1;
        err_in = alip_pkg::ERR_STREAM;
      end
      ph_d   = alip_pkg::PH_START;
      neg_d  = 1'b0;
      rx_d   = alip_pkg::RX_DEC;
      acc_d  = '0;
      stop_d = 1'b0;
    end else if (ph_q == alip_pkg::PH_AFTER_CR) begin
      if (char_byte_i != alip_pkg::CH_CR) begin
        emit = 1'b1;
        if (char_byte_i == alip_pkg::CH_LF) begin
          ph_d   = alip_pkg::PH_START;
          neg_d  = 1'b0;
          rx_d   = alip_pkg::RX_DEC;
          acc_d  = '0;
          stop_d = 1'b0;
        end else begin
          ph_d   = lc_ph;
          neg_d  = lc_neg;
          rx_d   = lc_rx;
          acc_d  = lc_acc;
          stop_d = lc_stop;
        end
      end
    end else if (char_byte_i == alip_pkg::CH_LF || char_byte_i == alip_pkg::CH_CR) begin
      if (ph_q == alip_pkg::PH_START || ph_q == alip_pkg::PH_BLANKS ||
          ph_q == alip_pkg::PH_SIGNED || ph_q == alip_pkg::PH_HEXPFX) begin
        emit_rx = alip_pkg::RX_NONE;
      end
      if (char_byte_i == alip_pkg::CH_CR) begin
        ph_d = alip_pkg::PH_AFTER_CR;
        rx_d = emit_rx;
      end else begin
        emit   = 1'b1;
        ph_d   = alip_pkg::PH_START;
        neg_d  = 1'b0;
        rx_d   = alip_pkg::RX_DEC;
        acc_d  = '0;
        stop_d = 1'b0;
      end
    end else begin
      ph_d   = lc_ph;
      neg_d  = lc_neg;
      rx_d   = lc_rx;
      acc_d  = lc_acc;
      stop_d = lc_stop;
    end
  end

  // result of a finished line
  always_comb begin
    mag     = acc_q;
    err_out = err_in;
    val     = '0;
    if (!neg_q && acc_q[alip_pkg::ACC_W-1]) mag = alip_pkg::MAG_CAP - alip_pkg::ACC_W'(1);
    if (err_out == alip_pkg::ERR_OK && emit_rx == alip_pkg::RX_NONE) begin
      err_out = alip_pkg::ERR_NODIG;
    end
    if (err_out == alip_pkg::ERR_OK) begin
      if (width_mode_i == alip_pkg::WM_8BIT &&
          mag > (neg_q ? alip_pkg::LIM8_NEG : alip_pkg::LIM8_POS)) begin
        err_out = alip_pkg::ERR_RANGE;
      end else if (width_mode_i == alip_pkg::WM_16BIT &&
                   mag > (neg_q ? alip_pkg::LIM16_NEG : alip_pkg::LIM16_POS)) begin
        err_out = alip_pkg::ERR_RANGE;
      end else begin
        val = neg_q ? (32'd0 - mag[31:0]) : mag[31:0];
      end
    end
    lines_d = lines_q + {31'd0, (emit && err_out == alip_pkg::ERR_OK)};
  end

  assign res_o.emit        = emit;
  assign res_o.value       = (err_out == alip_pkg::ERR_OK) ? signed'(val) : 32'sd0;
  assign res_o.error_code  = err_out;
  assign res_o.line_number = lines_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= alip_pkg::PH_START;
      neg_q   <= 1'b0;
      rx_q    <= alip_pkg::RX_DEC;
      acc_q   <= '0;
      stop_q  <= 1'b0;
      lines_q <= '0;
    end else if (step_i) begin
      ph_q    <= ph_d;
      neg_q   <= neg_d;
      rx_q    <= rx_d;
      acc_q   <= acc_d;
      stop_q  <= stop_d;
      lines_q <= lines_d;
    end
  end

endmodule

// File: hdl/ascii_integer_line_parser_unit.sv
// Top level of the integer line parser: input register, parser core, result register.
//
//   channel      dir  payload                               handshake
//   char_i       in   char_byte, stream_end                 valid / ready
//   result_o     out  value, error_code, line_number        valid / ready
//   width_mode   in   2-bit register                        write enable, no read-back
//
// One character per cycle sustained unless a result stalls; a request waits in the input
// register, and a finished line's result is written to the result register when the core steps.
// The register-to-register feedback loop is the parser state update (shift-add and saturation).
// Reset clears all control state and sets width_mode to 32-bit truncate.
// A stalled result holds the input register; input stays ready while either frees.
`include "ascii_integer_line_parser_unit_assert.svh"

module ascii_integer_line_parser_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                width_mode_we_i,
  input  logic [1:0]          width_mode_wdata_i,
  alip_char_if.sink           char_i,
  alip_result_if.source       result_o
);

  logic                in_valid_q;
  logic [7:0]          char_q;
  logic                end_q;
  logic                out_valid_q;
  logic [1:0]          width_mode_q;
  logic                fire;
  logic                in_take;
  alip_pkg::step_res_t core_res;
  logic signed [31:0]  value_q;
  alip_pkg::err_e      err_q;
  logic [31:0]         line_q;

  assign fire    = in_valid_q && (!out_valid_q || result_o.ready);
  assign in_take = char_i.valid && char_i.ready;

  assign char_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_mode_q <= alip_pkg::WIDTH_MODE_RST;
    end else if (width_mode_we_i) begin
      width_mode_q <= width_mode_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= char_i.char_byte;
      end_q  <= char_i.stream_end;
    end
  end

  alip_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (fire),
    .char_byte_i  (char_q),
    .stream_end_i (end_q),
    .width_mode_i (width_mode_q),
    .res_o        (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && core_res.emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && core_res.emit) begin
      value_q <= core_res.value;
      err_q   <= core_res.error_code;
      line_q  <= core_res.line_number;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.value       = value_q;
  assign result_o.error_code  = err_q;
  assign result_o.line_number = line_q;

  `ALIP_ASSERT_NOW(a_err_value_zero,
    out_valid_q && err_q != alip_pkg::ERR_OK, value_q == 32'sd0,
    "failed line carries a nonzero value")
  `ALIP_ASSERT_NOW(a_stall_blocks_input,
    in_valid_q && out_valid_q && !result_o.ready, !char_i.ready,
    "input taken while the input register is held")
  `ALIP_ASSERT_NEXT(a_drain_clears_valid,
    out_valid_q && result_o.ready && !(fire && core_res.emit), !out_valid_q,
    "result still shown after it was taken")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the integer line parser: text lines in, parsed values checked.
module tb;
  import alip_pkg::*;

  localparam int unsigned CLK_HALF      = 4;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 205;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS   = 10;

  localparam width_mode_e PHASE_MODES [PHASES] = '{
    WM_8BIT, WM_16BIT, WM_ALT32, WM_8BIT, WM_32BIT, WM_16BIT, WM_8BIT, WM_32BIT
  };
  localparam int unsigned GAP_PCTS [3] = '{0, 15, 40};
  localparam logic [63:0] LIMIT_MAGS [17] = '{
    64'd0, 64'd1, 64'd127, 64'd128, 64'd129, 64'd255, 64'd32767, 64'd32768, 64'd32769,
    64'd65535, 64'd2147483647, 64'd2147483648, 64'd4294967295, 64'd4294967296,
    64'd9223372036854775807, 64'd9223372036854775808, 64'd18446744073709551615
  };

  class parse_scoreboard;
    typedef struct packed {
      logic [31:0] value;
      err_e        error_code;
      logic [31:0] line_number;
    } line_result_t;

    width_mode_e  mode;
    phase_e       ph;
    logic         negative;
    radix_e       radix;
    logic [63:0]  magnitude;
    logic         stopped;
    logic [31:0]  lines_done;
    line_result_t expected_lines[$];
    int unsigned  mismatches;

    function new();
      mode       = WM_32BIT;
      lines_done = '0;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      ph        = PH_START;
      negative  = 1'b0;
      radix     = RX_DEC;
      magnitude = '0;
      stopped   = 1'b0;
    endfunction

    function logic [4:0] nibble_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 10);
      if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 10);
      return 5'd16;
    endfunction

    // Saturating shift-add of the magnitude.
    function void grow(logic [63:0] base, logic [4:0] d);
      logic [63:0] dw;
      dw = 64'(d);
      if (magnitude > (MAG_CAP - dw) / base) magnitude = MAG_CAP;
      else magnitude = magnitude * base + dw;
    endfunction

    function void add_digit(logic [4:0] d);
      if (radix == RX_OCT) begin
        if (stopped || d >= 5'd8) stopped = 1'b1;
        else grow(64'd8, d);
      end else if (radix == RX_HEX) begin
        grow(64'd16, d);
      end else begin
        grow(64'd10, d);
      end
    endfunction

    function void open_number(logic [7:0] c);
      if (c == CH_ZERO) begin
        ph = PH_ZERO;
      end else if (c >= CH_ONE && c <= CH_NINE) begin
        radix     = RX_DEC;
        magnitude = 64'(c - CH_ZERO);
        ph        = PH_DIGITS;
      end else begin
        radix = RX_NONE;
        ph    = PH_TAIL;
      end
    endfunction

    function void line_char(logic [7:0] c);
      logic [4:0] d;
      case (ph)
        PH_START, PH_BLANKS: begin
          if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
            ph = PH_BLANKS;
          end else if (c == CH_MINUS) begin
            negative = 1'b1;
            ph       = PH_SIGNED;
          end else if (c == CH_PLUS) begin
            ph = PH_SIGNED;
          end else begin
            open_number(c);
          end
        end
        PH_SIGNED: open_number(c);
        PH_ZERO: begin
          if (c == CH_X) begin
            ph = PH_HEXPFX;
          end else if (c >= CH_ZERO && c <= CH_NINE) begin
            radix = RX_OCT;
            ph    = PH_DIGITS;
            add_digit(5'(c - CH_ZERO));
          end else begin
            ph = PH_TAIL;
          end
        end
        PH_HEXPFX: begin
          d = nibble_of(c);
          if (d < 5'd16) begin
            radix = RX_HEX;
            ph    = PH_DIGITS;
            add_digit(d);
          end else begin
            radix = RX_NONE;
            ph    = PH_TAIL;
          end
        end
        PH_DIGITS: begin
          d = nibble_of(c);
          if (radix != RX_HEX && d > 5'd9) d = 5'd16;
          if (d < 5'd16) add_digit(d);
          else ph = PH_TAIL;
        end
        default: ;
      endcase
    endfunction

    function void close_line(err_e err);
      logic [63:0]  mag;
      logic [63:0]  neg_mag;
      err_e         e;
      line_result_t res;
      e         = err;
      res.value = '0;
      if (e == ERR_OK && radix == RX_NONE) e = ERR_NODIG;
      if (e == ERR_OK) begin
        mag = magnitude;
        if (!negative && mag > MAG_CAP - 64'd1) mag = MAG_CAP - 64'd1;
        neg_mag = 64'd0 - mag;
        if (mode == WM_8BIT && mag > (negative ? LIM8_NEG : LIM8_POS)) e = ERR_RANGE;
        else if (mode == WM_16BIT && mag > (negative ? LIM16_NEG : LIM16_POS)) e = ERR_RANGE;
        else res.value = negative ? neg_mag[31:0] : mag[31:0];
      end
      if (e == ERR_OK) lines_done++;
      else res.value = '0;
      res.error_code  = e;
      res.line_number = lines_done;
      expected_lines.push_back(res);
    endfunction

    // Accepted request on the character channel.
    function void take_char(logic [7:0] c, logic stream_end);
      if (stream_end) begin
        if (ph == PH_START) return;
        close_line(ERR_STREAM);
        clear_line();
        return;
      end
      if (ph == PH_AFTER_CR) begin
        if (c == CH_CR) return;
        close_line(ERR_OK);
        clear_line();
        if (c != CH_LF) line_char(c);
        return;
      end
      if (c == CH_LF || c == CH_CR) begin
        if (ph inside {PH_START, PH_BLANKS, PH_SIGNED, PH_HEXPFX}) radix = RX_NONE;
        if (c == CH_CR) begin
          ph = PH_AFTER_CR;
          return;
        end
        close_line(ERR_OK);
        clear_line();
        return;
      end
      line_char(c);
    endfunction

    function void check_line(logic [31:0] value, logic [1:0] error_code,
                             logic [31:0] line_number);
      line_result_t want;
      if (expected_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: value %0d error %0d line %0d",
                   $signed(value), error_code, line_number);
        return;
      end
      want = expected_lines.pop_front();
      if (value !== want.value || error_code !== want.error_code ||
          line_number !== want.line_number) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected value %0d error %0d line %0d, got value %0d error %0d line %0d",
                   $signed(want.value), want.error_code, want.line_number,
                   $signed(value), error_code, line_number);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       width_mode_we_i = 1'b0;
  logic [1:0] width_mode_wdata_i = WM_32BIT;

  alip_char_if   char_if ();
  alip_result_if result_if ();

  ascii_integer_line_parser_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .width_mode_we_i    (width_mode_we_i),
    .width_mode_wdata_i (width_mode_wdata_i),
    .char_i             (char_if),
    .result_o           (result_if)
  );

  parse_scoreboard sb;
  logic [8:0]      char_plan[$];
  int unsigned     items_sent;
  int unsigned     src_gap_pct;
  int unsigned     snk_gap_pct;
  int unsigned     snk_hold;
  int unsigned     cycles;
  bit              calm;

  always #(CLK_HALF) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready)
      sb.check_line(result_if.value, result_if.error_code, result_if.line_number);
  end

  // Random result back-pressure in bursts; none while calm.
  always @(negedge clk_i) begin
    if (calm) begin
      snk_hold = 0;
      result_if.ready <= 1'b1;
    end else if (snk_hold > 0) begin
      snk_hold--;
      result_if.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < snk_gap_pct) begin
      snk_hold = $urandom_range(1, 3) - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  function automatic void push_byte(logic [7:0] c);
    char_plan.push_back({1'b0, c});
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_end();
    char_plan.push_back({1'b1, 8'($urandom_range(0, 255))});
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    string digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  // One line of text: mostly well-formed numbers, some noise.
  function automatic void build_line();
    int unsigned kind;
    int unsigned n;
    string       s;
    logic [63:0] v;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      n = $urandom_range(1, 8);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
    end else begin
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) push_byte(blank_char());
      case ($urandom_range(0, 2))
        1: push_byte(CH_PLUS);
        2: push_byte(CH_MINUS);
        default: ;
      endcase
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        n = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 5) : $urandom_range(6, 21);
        push_byte(8'(CH_ONE + $urandom_range(0, 8)));
        repeat (n - 1) push_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      end else if (kind < 5) begin
        push_byte(CH_ZERO);
        n = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 6) : $urandom_range(7, 24);
        repeat (n) push_byte(8'(CH_ZERO + (($urandom_range(0, 7) != 0) ?
                                          $urandom_range(0, 7) : $urandom_range(8, 9))));
      end else if (kind < 7) begin
        push_byte(CH_ZERO);
        push_byte(CH_X);
        n = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 4) : $urandom_range(5, 18);
        repeat (n) push_byte(hex_char());
      end else if (kind < 9) begin
        v = LIMIT_MAGS[$urandom_range(0, 16)];
        case ($urandom_range(0, 2))
          0: s = $sformatf("%0d", v);
          1: s = $sformatf("0x%0h", v);
          default: s = $sformatf("0%0o", v);
        endcase
        push_text(s);
      end else begin
        case ($urandom_range(0, 2))
          0: ;
          1: push_text("0X");
          default: push_byte(8'($urandom_range(8'h21, 8'h7e)));
        endcase
      end
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) push_byte(8'($urandom_range(8'h20, 8'hff)));
      end
    end
    kind = $urandom_range(0, 19);
    if (kind < 9) begin
      push_byte(CH_LF);
    end else if (kind < 13) begin
      push_byte(CH_CR);
      push_byte(CH_LF);
    end else if (kind < 16) begin
      push_byte(CH_CR);
    end else if (kind == 16) begin
      push_byte(CH_CR);
      push_byte(CH_CR);
      push_byte(CH_LF);
    end else if (kind == 17) begin
      push_byte(CH_CR);
      push_byte(CH_CR);
    end else if (kind == 18) begin
      push_byte(CH_CR);
      push_end();
    end else begin
      push_end();
      if ($urandom_range(0, 1) == 0) push_end();
    end
  endfunction

  // Called at a falling edge, returns at a falling edge.
  task automatic send_item(input logic [8:0] item);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < src_gap_pct) begin
      gap = $urandom_range(1, 3);
      char_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    char_if.valid      <= 1'b1;
    char_if.char_byte  <= item[7:0];
    char_if.stream_end <= item[8];
    do @(posedge clk_i); while (!char_if.ready);
    sb.take_char(item[7:0], item[8]);
    @(negedge clk_i);
  endtask

  task automatic send_plan();
    while (char_plan.size() != 0) begin
      send_item(char_plan.pop_front());
      items_sent++;
    end
  endtask

  task automatic drain_and_settle();
    char_if.valid <= 1'b0;
    while (sb.expected_lines.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_mode(input width_mode_e m);
    width_mode_we_i    <= 1'b1;
    width_mode_wdata_i <= m;
    @(negedge clk_i);
    width_mode_we_i <= 1'b0;
    sb.mode = m;
  endtask

  initial begin
    sb                 = new();
    char_if.valid      = 1'b0;
    char_if.char_byte  = '0;
    char_if.stream_end = 1'b0;
    result_if.ready    = 1'b0;
    calm               = 1'b0;
    src_gap_pct        = 20;
    snk_gap_pct        = 20;
    snk_hold           = 0;
    cycles             = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty line; sign and 0x without digits over a CR run; 0X; octal stopped at 9;
    // high byte then CR followed by a digit; stream end mid-line and on a fresh line
    push_byte(CH_LF);
    push_byte(CH_VT);
    push_text("-0x");
    push_byte(CH_CR);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_text("0X1");
    push_byte(CH_LF);
    push_text("079");
    push_byte(CH_LF);
    push_byte(8'hff);
    push_text("5");
    push_byte(CH_CR);
    push_text("9");
    push_end();
    push_end();
    push_byte(8'h00);
    push_byte(CH_LF);
    send_plan();
    drain_and_settle();

    for (int p = 0; p < PHASES; p++) begin
      write_mode(PHASE_MODES[p]);
      calm        = (p == PHASES - 1);
      src_gap_pct = calm ? 0 : GAP_PCTS[$urandom_range(0, 2)];
      snk_gap_pct = calm ? 0 : GAP_PCTS[$urandom_range(0, 2)];
      items_sent  = 0;
      while (items_sent < PHASE_ITEMS) begin
        build_line();
        send_plan();
      end
      drain_and_settle();
    end

    if (sb.mismatches == 0 && sb.expected_lines.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
